// ----- hw/rtl/fpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

	// Default width of the move clocks
	localparam int CLOCK_BITS_DEF = 16;

	// Board storage
	localparam int BOARD_W    = 64;
	localparam int NUM_BOARDS = 8;
	localparam int NUM_COLOUR = 2;
	localparam int NUM_PIECE  = 6;
	localparam int COL_AW     = $clog2(NUM_COLOUR);
	localparam int PC_AW      = $clog2(NUM_PIECE);
	localparam int IDX_W      = $clog2(NUM_BOARDS);

	// Scalar widths on the result beat
	localparam int OUT_CLK_W = 16;
	localparam int EP_W      = 7;
	localparam logic [EP_W-1:0] NO_SQUARE = 7'd64;

	// Board indexes
	localparam logic [IDX_W-1:0] IDX_WHITE  = 3'd0;
	localparam logic [IDX_W-1:0] IDX_BLACK  = 3'd1;
	localparam logic [IDX_W-1:0] IDX_PAWN   = 3'd2;
	localparam logic [IDX_W-1:0] IDX_KNIGHT = 3'd3;
	localparam logic [IDX_W-1:0] IDX_BISHOP = 3'd4;
	localparam logic [IDX_W-1:0] IDX_ROOK   = 3'd5;
	localparam logic [IDX_W-1:0] IDX_QUEEN  = 3'd6;
	localparam logic [IDX_W-1:0] IDX_KING   = 3'd7;
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_KING;

	// Field numbers
	localparam logic [2:0] FLD_PLACE  = 3'd0;
	localparam logic [2:0] FLD_SIDE   = 3'd1;
	localparam logic [2:0] FLD_CASTLE = 3'd2;
	localparam logic [2:0] FLD_EP     = 3'd3;
	localparam logic [2:0] FLD_HALF   = 3'd4;
	localparam logic [2:0] FLD_FULL   = 3'd5;
	localparam logic [2:0] FLD_MAX    = 3'd6;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_UK    = 8'h4B;
	localparam logic [7:0] CH_UQ    = 8'h51;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_K     = 8'h6B;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_LOAD,
		S_HOLD
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fen_position_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// FEN position parser. Feed the FEN text one character per input beat and mark
// the last character with s_tlast. A piece letter that lands on a square of the
// board needs a write-back: the colour and piece boards are read from their
// memories in the accept cycle and written back in the next. Other characters
// need no write-back. After the last character the block sends eight result
// beats, boards white, black, pawn, knight, bishop, rook, queen and king in that
// order, each with the same side, castling, en passant, clock and error fields;
// m_tlast marks the king board. Each result beat passes through memory read,
// load and hand-over, and waits in hand-over while m_tready is low; no input is
// taken until the eighth beat has gone. Boards read as empty after reset and
// after each run.

module fen_position_parser #(
	parameter int CLOCK_BITS = fpp_pkg::CLOCK_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] char_code
	input  wire logic         s_tlast,  // final_char
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,  // [63:0] board_bits, [64] side_to_move,
	                                    // [68:65] castling_bits,
	                                    // [75:69] en_passant_square,
	                                    // [91:76] halfmove_count,
	                                    // [107:92] fullmove_count, [108] bad_input,
	                                    // [111:109] zero
	output logic [2:0]        m_tuser,  // [2:0] board_index
	output logic              m_tlast   // last_board
);

	import fpp_pkg::*;

	localparam logic [CLOCK_BITS-1:0] CLK_LIM = {CLOCK_BITS{1'b1}};
	localparam logic [CLOCK_BITS-1:0] CLK_ONE = CLOCK_BITS'(1);

	state_t state_q, state_d;

	// Parser state
	logic [3:0]            rank_q;
	logic [4:0]            file_q;
	logic [2:0]            fn_q;
	logic [1:0]            fcc_q;
	logic                  side_q;
	logic [3:0]            castle_q;
	logic [EP_W-1:0]       ep_q;
	logic [CLOCK_BITS-1:0] half_q;
	logic [CLOCK_BITS-1:0] full_q;
	logic                  err_q;

	// Next values after one character
	logic [3:0]            rank_n;
	logic [4:0]            file_n;
	logic [2:0]            fn_n;
	logic [1:0]            fcc_n;
	logic                  side_n;
	logic [3:0]            castle_n;
	logic [EP_W-1:0]       ep_n;
	logic [CLOCK_BITS-1:0] half_n;
	logic [CLOCK_BITS-1:0] full_n;
	logic                  err_n;

	// Values latched for the result beats
	logic                  o_side_q;
	logic [3:0]            o_castle_q;
	logic [EP_W-1:0]       o_ep_q;
	logic [OUT_CLK_W-1:0]  o_half_q;
	logic [OUT_CLK_W-1:0]  o_full_q;
	logic                  o_err_q;
	logic [BOARD_W-1:0]    o_bits_q;

	// Board memories and their valid bits
	logic [BOARD_W-1:0]    col_mem [NUM_COLOUR];
	logic [BOARD_W-1:0]    pc_mem  [NUM_PIECE];
	logic [BOARD_W-1:0]    col_rd_q, pc_rd_q;
	logic [COL_AW-1:0]     col_ra, col_ra_q;
	logic [PC_AW-1:0]      pc_ra, pc_ra_q;
	logic [NUM_COLOUR-1:0] col_vld_q;
	logic [NUM_PIECE-1:0]  pc_vld_q;
	logic [BOARD_W-1:0]    col_old, pc_old, put_mask;

	logic [5:0]            sq_q;
	logic                  fin_q;
	logic [IDX_W-1:0]      k_q;

	// Character decode
	logic [7:0]            ch, lc;
	logic                  accept, is_space, is_digit, is_upper, is_piece, do_put;
	logic                  cd_ep_void, out_full_one;
	logic [3:0]            dval;
	logic [5:0]            file_sum;
	logic [IDX_W-1:0]      piece_idx;
	logic [CLOCK_BITS+3:0] clk_acc, clk_v;
	logic [EP_W-1:0]       ep_fin;
	logic                  err_fin;
	logic [CLOCK_BITS-1:0] full_fin;
	logic [CLOCK_BITS+OUT_CLK_W-1:0] half_ext, full_ext;

	assign ch       = s_tdata;
	assign accept   = s_tvalid && s_tready;
	assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign is_upper = (ch >= CH_UA) && (ch <= CH_UZ);
	assign lc       = is_upper ? ch + CASE_GAP : ch;
	assign dval     = 4'(ch - CH_0);
	assign file_sum = {1'b0, file_q} + {2'b00, dval};

	// Map the lower-case letter to its piece board
	always_comb begin
		is_piece  = 1'b1;
		piece_idx = IDX_PAWN;
		unique case (lc)
			CH_P:    piece_idx = IDX_PAWN;
			CH_N:    piece_idx = IDX_KNIGHT;
			CH_B:    piece_idx = IDX_BISHOP;
			CH_R:    piece_idx = IDX_ROOK;
			CH_Q:    piece_idx = IDX_QUEEN;
			CH_K:    piece_idx = IDX_KING;
			default: is_piece = 1'b0;
		endcase
	end

	// Clock digit accumulate with saturation
	always_comb begin
		clk_acc = (fn_q == FLD_HALF) ? {4'b0000, half_q} : {4'b0000, full_q};
		clk_v   = (clk_acc << 3) + (clk_acc << 1) + {{CLOCK_BITS{1'b0}}, dval};
	end

	// Work out the state after this character
	always_comb begin
		rank_n   = rank_q;
		file_n   = file_q;
		fn_n     = fn_q;
		fcc_n    = fcc_q;
		side_n   = side_q;
		castle_n = castle_q;
		ep_n     = ep_q;
		half_n   = half_q;
		full_n   = full_q;
		err_n    = err_q;
		do_put   = 1'b0;
		if (is_space) begin
			if (fcc_q != 2'd0) begin
				if (fn_q == FLD_EP && fcc_q == 2'd1 && ep_q != NO_SQUARE) begin
					ep_n  = NO_SQUARE;
					err_n = 1'b1;
				end
				if (fn_q < FLD_MAX) fn_n = fn_q + 3'd1;
				fcc_n = 2'd0;
			end
		end else begin
			case (fn_q)
				FLD_PLACE: begin
					if (ch == CH_SLASH) begin
						rank_n = (rank_q == 4'd0 || rank_q > 4'd7) ? 4'd15 : rank_q - 4'd1;
						file_n = 5'd0;
					end else if (is_digit) begin
						file_n = (file_sum > 6'd31) ? 5'd31 : file_sum[4:0];
					end else if (!is_piece) begin
						err_n = 1'b1;
					end else begin
						if (rank_q > 4'd7 || file_q > 5'd7) err_n = 1'b1;
						else do_put = 1'b1;
						if (file_q < 5'd31) file_n = file_q + 5'd1;
					end
				end
				FLD_SIDE: side_n = !(fcc_q == 2'd0 && ch == CH_W);
				FLD_CASTLE: begin
					if (ch == CH_UK) castle_n[0] = 1'b1;
					if (ch == CH_UQ) castle_n[1] = 1'b1;
					if (ch == CH_K)  castle_n[2] = 1'b1;
					if (ch == CH_Q)  castle_n[3] = 1'b1;
				end
				FLD_EP: begin
					if (fcc_q == 2'd0) begin
						if (ch >= CH_A && ch <= CH_H) begin
							ep_n = EP_W'(ch - CH_A);
						end else begin
							ep_n = NO_SQUARE;
							if (ch != CH_DASH) err_n = 1'b1;
						end
					end else if (fcc_q == 2'd1 && ep_q != NO_SQUARE) begin
						if (ch >= CH_1 && ch <= CH_8) begin
							ep_n = {1'b0, 3'(ch - CH_1), ep_q[2:0]};
						end else begin
							ep_n  = NO_SQUARE;
							err_n = 1'b1;
						end
					end
				end
				FLD_HALF, FLD_FULL: begin
					if (is_digit) begin
						if (fn_q == FLD_HALF) begin
							half_n = (clk_v > {4'b0000, CLK_LIM}) ? CLK_LIM : clk_v[CLOCK_BITS-1:0];
						end else begin
							full_n = (clk_v > {4'b0000, CLK_LIM}) ? CLK_LIM : clk_v[CLOCK_BITS-1:0];
						end
					end else begin
						err_n = 1'b1;
					end
				end
				default: ;
			endcase
			if (fcc_q < 2'd3) fcc_n = fcc_q + 2'd1;
		end
	end

	// Close the last field at the end of the string
	always_comb begin
		cd_ep_void   = (fn_n == FLD_EP) && (fcc_n == 2'd1) && (ep_n != NO_SQUARE);
		ep_fin       = cd_ep_void ? NO_SQUARE : ep_n;
		err_fin      = err_n || cd_ep_void;
		out_full_one = (fn_n < FLD_FULL) || (fn_n == FLD_FULL && fcc_n == 2'd0);
		full_fin     = out_full_one ? CLK_ONE : full_n;
		half_ext     = {{OUT_CLK_W{1'b0}}, half_n};
		full_ext     = {{OUT_CLK_W{1'b0}}, full_fin};
	end

	// Parser registers: update per beat, return to reset after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= 4'd7;
			file_q   <= 5'd0;
			fn_q     <= FLD_PLACE;
			fcc_q    <= 2'd0;
			side_q   <= 1'b0;
			castle_q <= 4'd0;
			ep_q     <= NO_SQUARE;
			half_q   <= '0;
			full_q   <= '0;
			err_q    <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				rank_q   <= 4'd7;
				file_q   <= 5'd0;
				fn_q     <= FLD_PLACE;
				fcc_q    <= 2'd0;
				side_q   <= 1'b0;
				castle_q <= 4'd0;
				ep_q     <= NO_SQUARE;
				half_q   <= '0;
				full_q   <= '0;
				err_q    <= 1'b0;
			end else begin
				rank_q   <= rank_n;
				file_q   <= file_n;
				fn_q     <= fn_n;
				fcc_q    <= fcc_n;
				side_q   <= side_n;
				castle_q <= castle_n;
				ep_q     <= ep_n;
				half_q   <= half_n;
				full_q   <= full_n;
				err_q    <= err_n;
			end
		end
	end

	// Latch the scalars of the run and the square to set
	always_ff @(posedge clk) begin
		if (accept) begin
			sq_q  <= {rank_q[2:0], file_q[2:0]};
			fin_q <= s_tlast;
			if (s_tlast) begin
				o_side_q   <= side_n;
				o_castle_q <= castle_n;
				o_ep_q     <= ep_fin;
				o_half_q   <= half_ext[OUT_CLK_W-1:0];
				o_full_q   <= full_ext[OUT_CLK_W-1:0];
				o_err_q    <= err_fin;
			end
		end
	end

	// Choose the memory read addresses
	always_comb begin
		if (state_q == S_READ) begin
			col_ra = k_q[COL_AW-1:0];
			pc_ra  = (k_q < IDX_PAWN) ? '0 : PC_AW'(k_q - IDX_PAWN);
		end else begin
			col_ra = is_upper ? COL_AW'(IDX_WHITE) : COL_AW'(IDX_BLACK);
			pc_ra  = is_piece ? PC_AW'(piece_idx - IDX_PAWN) : '0;
		end
	end

	assign col_old  = col_vld_q[col_ra_q] ? col_rd_q : '0;
	assign pc_old   = pc_vld_q[pc_ra_q] ? pc_rd_q : '0;
	assign put_mask = BOARD_W'(1) << sq_q;

	// Board memories: read every cycle, write back in the write state
	always_ff @(posedge clk) begin
		col_rd_q <= col_mem[col_ra];
		pc_rd_q  <= pc_mem[pc_ra];
		col_ra_q <= col_ra;
		pc_ra_q  <= pc_ra;
		if (state_q == S_WRITE) begin
			col_mem[col_ra_q] <= col_old | put_mask;
			pc_mem[pc_ra_q]   <= pc_old | put_mask;
		end
	end

	// Valid bits: set on write-back, clear after the last result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_vld_q <= '0;
			pc_vld_q  <= '0;
		end else if (state_q == S_WRITE) begin
			col_vld_q[col_ra_q] <= 1'b1;
			pc_vld_q[pc_ra_q]   <= 1'b1;
		end else if (state_q == S_HOLD && m_tready && k_q == IDX_LAST) begin
			col_vld_q <= '0;
			pc_vld_q  <= '0;
		end
	end

	// Board counter for the result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (state_q == S_HOLD && m_tready) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// Load the board read for this beat
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			o_bits_q <= (k_q < IDX_PAWN) ? col_old : pc_old;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (do_put)        state_d = S_WRITE;
					else if (s_tlast)  state_d = S_READ;
				end
			end
			S_WRITE: state_d = fin_q ? S_READ : S_IDLE;
			S_READ:  state_d = S_LOAD;
			S_LOAD:  state_d = S_HOLD;
			S_HOLD: begin
				if (m_tready) state_d = (k_q == IDX_LAST) ? S_IDLE : S_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// Handshake outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_HOLD:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = {3'b000, o_err_q, o_full_q, o_half_q, o_ep_q, o_castle_q, o_side_q,
		o_bits_q};
	assign m_tuser = k_q;
	assign m_tlast = (k_q == IDX_LAST);

endmodule

`default_nettype wire
